[rtl/cbpu_pkg.sv]
// Shared types and constants of the codebook background pixel update block.
package cbpu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRAINING_FRAMES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_Q8           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_EPSILON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_AGE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERMANENT_TIMEOUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ABSORB_AGE        = 3'd7;

  localparam logic [15:0] RST_TRAINING_FRAMES   = 16'd200;
  localparam logic [7:0]  RST_ALPHA_Q8          = 8'd205;
  localparam logic [8:0]  RST_BETA_Q8           = 9'd282;
  localparam logic [9:0]  RST_COLOR_EPSILON     = 10'd20;
  localparam logic [15:0] RST_CACHE_TIMEOUT     = 16'd20;
  localparam logic [15:0] RST_PROMOTE_AGE       = 16'd150;
  localparam logic [15:0] RST_PERMANENT_TIMEOUT = 16'd3000;
  localparam logic [15:0] RST_ABSORB_AGE        = 16'd30;

  // iteration counter load values of the shared sqrt and divide units
  localparam int ITER_W = 5;
  localparam logic [ITER_W-1:0] SQRT_LAST = 5'd16;
  localparam logic [ITER_W-1:0] DIV_LAST  = 5'd15;

  typedef enum logic [1:0] {
    CLS_BG     = 2'd0,
    CLS_RECENT = 2'd1,
    CLS_CACHED = 2'd2,
    CLS_FG     = 2'd3
  } cls_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SQRT, ST_CNT, ST_WRD, ST_WLD,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DEC,
    ST_MUL, ST_NUM, ST_DIV, ST_WCOL, ST_UPD, ST_PRN, ST_KEEP,
    ST_NEW, ST_DONE
  } state_t;

  // one codeword; color[0] blue, color[1] green, color[2] red (Q8.8)
  typedef struct packed {
    logic [2:0][15:0] color;
    logic [16:0]      imin;
    logic [16:0]      imax;
    logic [15:0]      freq;
    logic [31:0]      idle_run;
    logic [31:0]      first_t;
    logic [31:0]      last_t;
    logic             cached;
  } word_t;

  typedef struct packed {
    logic clr;
    logic load_px;
    logic sqrt_step;
    logic cnt_load;
    logic ld_word;
    logic m1;
    logic m2;
    logic m3;
    logic m4;
    logic m5;
    logic mul;
    logic num;
    logic div_step;
    logic wr_col;
    logic upd;
    logic prn;
    logic keep;
    logic add_new;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_range;
    logic words_left;
    logic match;
    logic col_last;
  } status_t;

endpackage

[rtl/cbpu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cbpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/cbpu_ctrl.sv]
// Controller state machine: sequences clearing, sqrt, word walk and result.
module cbpu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cbpu_pkg::status_t st,
  output cbpu_pkg::cmd_t   cmd
);
  import cbpu_pkg::*;

  state_t state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (st.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (iter_r == '0) state_nxt = st.out_range ? ST_DONE : ST_CNT;
      end
      ST_CNT:  state_nxt = ST_WRD;
      ST_WRD:  state_nxt = st.words_left ? ST_WLD : ST_NEW;
      ST_WLD:  state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_DEC;
      ST_DEC:  state_nxt = st.match ? ST_MUL : ST_PRN;
      ST_MUL:  state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_DIV;
      ST_DIV:  if (iter_r == '0) state_nxt = ST_WCOL;
      ST_WCOL: state_nxt = st.col_last ? ST_UPD : ST_MUL;
      ST_UPD:  state_nxt = ST_PRN;
      ST_PRN:  state_nxt = ST_KEEP;
      ST_KEEP: state_nxt = ST_WRD;
      ST_NEW:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    iter_nxt = iter_r;
    if (state_r == ST_IDLE) begin
      iter_nxt = SQRT_LAST;
    end else if (state_r == ST_NUM) begin
      iter_nxt = DIV_LAST;
    end else if ((state_r == ST_SQRT || state_r == ST_DIV) && iter_r != '0) begin
      iter_nxt = iter_r - 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clr       = 1'b1;
      ST_IDLE:  cmd.load_px   = start;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_CNT:   cmd.cnt_load  = 1'b1;
      ST_WLD:   cmd.ld_word   = 1'b1;
      ST_M1:    cmd.m1        = 1'b1;
      ST_M2:    cmd.m2        = 1'b1;
      ST_M3:    cmd.m3        = 1'b1;
      ST_M4:    cmd.m4        = 1'b1;
      ST_M5:    cmd.m5        = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_NUM:   cmd.num       = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_WCOL:  cmd.wr_col    = 1'b1;
      ST_UPD:   cmd.upd       = 1'b1;
      ST_PRN:   cmd.prn       = 1'b1;
      ST_KEEP:  cmd.keep      = 1'b1;
      ST_NEW:   cmd.add_new   = 1'b1;
      ST_DONE:  cmd.finish    = 1'b1;
      default:  cmd           = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[rtl/cbpu_dp.sv]
// Datapath: configuration, frame state, sqrt and divide units, word arithmetic.
module cbpu_dp #(
  parameter int PIXELS = 16384,
  parameter int WORDS_PER_PIXEL = 8,
  localparam int CAW = (PIXELS > 1) ? $clog2(PIXELS) : 1,
  localparam int AW  = (PIXELS * WORDS_PER_PIXEL > 1) ? $clog2(PIXELS * WORDS_PER_PIXEL) : 1,
  localparam int CW  = $clog2(WORDS_PER_PIXEL + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbpu_pkg::cmd_t                   cmd,
  output cbpu_pkg::status_t                st,
  input  logic [13:0]                      in_pixel_index,
  input  logic                             in_frame_start,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_red,
  input  logic                             cfg_we,
  input  logic [cbpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbpu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             cnt_we,
  output logic [CAW-1:0]                   cnt_waddr,
  output logic [CW-1:0]                    cnt_wdata,
  output logic [CAW-1:0]                   cnt_raddr,
  input  logic [CW-1:0]                    cnt_rdata,
  output logic                             wd_we,
  output logic [AW-1:0]                    wd_waddr,
  output cbpu_pkg::word_t                  wd_wdata,
  output logic [AW-1:0]                    wd_raddr,
  input  cbpu_pkg::word_t                  wd_rdata,
  output logic                             out_valid,
  output logic [1:0]                       out_pixel_class,
  output logic                             out_foreground,
  output logic                             out_training
);
  import cbpu_pkg::*;

  // configuration
  logic [15:0] trn_r, cache_to_r, promote_r, perm_to_r, absorb_r;
  logic [7:0]  alpha_r;
  logic [8:0]  beta_r;
  logic [9:0]  eps_r;

  logic [31:0] frame_cnt_r, frame_cnt_nxt;
  logic        training_r, training_nxt;
  logic [CAW-1:0] clr_addr_r;

  // per-pixel
  logic [CAW-1:0]  idx_r;
  logic [AW-1:0]   base_r;
  logic            out_range_r;
  logic [2:0][7:0] x_r;
  logic [17:0]     p2_r;
  logic [19:0]     eps2_r;
  logic [10:0]     alpha7_r, beta3_r;
  logic [33:0]     sq_val_r;
  logic [18:0]     sq_rem_r;
  logic [16:0]     ii_r;
  logic [CW-1:0]   n_r, k_r, mp_r, mf_r;
  logic            perm_r, cache_r, active_r;
  cls_t            cls_r;

  // per-word
  word_t            w_r;
  logic [2:0][23:0] xv_r;
  logic [2:0][31:0] vv_r;
  logic [25:0]      d_r;
  logic [33:0]      v_r;
  logic [49:0]      pvl_r;
  logic [19:0]      pvh_r;
  logic [51:0]      dd_r, evl_r, pv_r;
  logic [21:0]      evh_r;
  logic [53:0]      ev_r;
  logic [27:0]      a7m_r, b3m_r;
  logic [24:0]      ai_r;
  logic             band_r, match_r;
  logic [1:0]       col_r;
  logic [31:0]      prod_r;
  logic [32:0]      div_r;

  logic             out_valid_r, out_fg_r, out_tr_r;
  cls_t             out_cls_r;

  // combinational helpers
  logic [17:0] p2_in;
  logic [20:0] sq_rem4;
  logic [20:0] sq_trial;
  logic [16:0] dvs;
  logic [17:0] div_t, div_ts;
  logic        div_ge;
  logic [51:0] lhs;
  logic        color_ok;
  logic        prune_on, prune_keep, exp_keep, new_ok;
  logic [15:0] lim;
  logic [31:0] run_cur;
  logic        absorb_ok;
  logic        promote_ok;
  logic [34:0] prune_t;
  logic        prune_upd;
  word_t       new_word;

  assign p2_in = 18'(in_blue * in_blue) + 18'(in_green * in_green) + 18'(in_red * in_red);

  always_comb begin
    frame_cnt_nxt = frame_cnt_r;
    training_nxt  = training_r;
    if (in_frame_start) begin
      if (frame_cnt_r != '0 && frame_cnt_r >= {16'b0, trn_r}) training_nxt = 1'b0;
      if (frame_cnt_r != '1) frame_cnt_nxt = frame_cnt_r + 32'd1;
    end
  end

  assign sq_rem4  = {sq_rem_r, sq_val_r[33:32]};
  assign sq_trial = {2'b0, ii_r, 2'b01};

  assign dvs    = 17'(w_r.freq) + 17'd1;
  assign div_t  = {div_r[32:16], div_r[15]};
  assign div_ge = div_t >= {1'b0, dvs};
  assign div_ts = div_ge ? div_t - {1'b0, dvs} : div_t;

  // Cauchy-Schwarz keeps this nonnegative
  assign lhs      = pv_r - dd_r;
  assign color_ok = (v_r == '0) ? ({2'b0, p2_r} <= eps2_r) : ({2'b0, lhs} <= ev_r);

  assign run_cur    = (frame_cnt_r >= w_r.last_t) ? frame_cnt_r - w_r.last_t : '0;
  assign absorb_ok  = ({1'b0, w_r.first_t} + 33'(absorb_r) <= {1'b0, frame_cnt_r}) ||
                      (w_r.first_t <= {16'b0, trn_r});
  assign promote_ok = active_r && !training_r && w_r.cached &&
                      ({1'b0, frame_cnt_r} >= {1'b0, w_r.first_t} + 33'(promote_r));

  // wrap-around idle run at the end of training
  assign prune_on  = (frame_cnt_r == {16'b0, trn_r});
  assign prune_t   = 35'({19'b0, trn_r}) - 35'({3'b0, w_r.last_t}) +
                     35'({3'b0, w_r.first_t}) - 35'd1;
  assign prune_upd = prune_on && !prune_t[34] && (prune_t[33:0] > {2'b0, w_r.idle_run});

  assign prune_keep = !prune_on || (w_r.idle_run <= 32'(trn_r >> 1));
  assign lim        = w_r.cached ? cache_to_r : perm_to_r;
  assign exp_keep   = training_r ||
                      ({1'b0, frame_cnt_r} < {1'b0, w_r.last_t} + 33'(lim));
  assign new_ok     = !perm_r && !cache_r && (mp_r < CW'(WORDS_PER_PIXEL)) &&
                      (training_r || cache_to_r != '0);

  always_comb begin
    new_word.color[0] = {x_r[0], 8'b0};
    new_word.color[1] = {x_r[1], 8'b0};
    new_word.color[2] = {x_r[2], 8'b0};
    new_word.imin     = ii_r;
    new_word.imax     = ii_r;
    new_word.freq     = 16'd1;
    new_word.idle_run = (frame_cnt_r != '0) ? frame_cnt_r - 32'd1 : '0;
    new_word.first_t  = frame_cnt_r;
    new_word.last_t   = frame_cnt_r;
    new_word.cached   = !training_r;
  end

  // memory ports
  assign cnt_we    = cmd.clr || (cmd.finish && !out_range_r);
  assign cnt_waddr = cmd.clr ? clr_addr_r : idx_r;
  assign cnt_wdata = cmd.clr ? '0 : mf_r;
  assign cnt_raddr = cmd.load_px ? CAW'(in_pixel_index) : idx_r;
  assign wd_raddr  = base_r + AW'(k_r);
  assign wd_waddr  = base_r + AW'(mf_r);
  assign wd_we     = (cmd.keep && prune_keep && exp_keep) || (cmd.add_new && new_ok);
  assign wd_wdata  = cmd.add_new ? new_word : w_r;

  assign st.clr_done   = (clr_addr_r == CAW'(PIXELS - 1));
  assign st.out_range  = out_range_r;
  assign st.words_left = (k_r < n_r);
  assign st.match      = match_r;
  assign st.col_last   = (col_r == 2'd2);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trn_r       <= RST_TRAINING_FRAMES;
      alpha_r     <= RST_ALPHA_Q8;
      beta_r      <= RST_BETA_Q8;
      eps_r       <= RST_COLOR_EPSILON;
      cache_to_r  <= RST_CACHE_TIMEOUT;
      promote_r   <= RST_PROMOTE_AGE;
      perm_to_r   <= RST_PERMANENT_TIMEOUT;
      absorb_r    <= RST_ABSORB_AGE;
      frame_cnt_r <= '0;
      training_r  <= 1'b1;
      clr_addr_r  <= '0;
      k_r         <= '0;
      mp_r        <= '0;
      mf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRAINING_FRAMES:   trn_r      <= cfg_wdata;
          REG_ALPHA_Q8:          alpha_r    <= cfg_wdata[7:0];
          REG_BETA_Q8:           beta_r     <= cfg_wdata[8:0];
          REG_COLOR_EPSILON:     eps_r      <= cfg_wdata[9:0];
          REG_CACHE_TIMEOUT:     cache_to_r <= cfg_wdata;
          REG_PROMOTE_AGE:       promote_r  <= cfg_wdata;
          REG_PERMANENT_TIMEOUT: perm_to_r  <= cfg_wdata;
          REG_ABSORB_AGE:        absorb_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.load_px) begin
        frame_cnt_r <= frame_cnt_nxt;
        training_r  <= training_nxt;
      end
      if (cmd.cnt_load) begin
        k_r  <= '0;
        mp_r <= '0;
        mf_r <= '0;
      end
      if (cmd.keep) begin
        k_r <= k_r + 1'b1;
        if (prune_keep) mp_r <= mp_r + 1'b1;
        if (prune_keep && exp_keep) mf_r <= mf_r + 1'b1;
      end
      if (cmd.add_new && new_ok) mf_r <= mf_r + 1'b1;
      out_valid_r <= cmd.finish;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      idx_r       <= CAW'(in_pixel_index);
      base_r      <= AW'(AW'(in_pixel_index) * AW'(WORDS_PER_PIXEL));
      out_range_r <= (32'(in_pixel_index) >= PIXELS);
      x_r[0]      <= in_blue;
      x_r[1]      <= in_green;
      x_r[2]      <= in_red;
      p2_r        <= p2_in;
      sq_val_r    <= {p2_in, 16'b0};
      sq_rem_r    <= '0;
      ii_r        <= '0;
      eps2_r      <= 20'(eps_r) * 20'(eps_r);
      alpha7_r    <= 11'(alpha_r) * 11'd7;
      beta3_r     <= 11'(beta_r) * 11'd3;
      perm_r      <= 1'b0;
      cache_r     <= 1'b0;
      active_r    <= 1'b1;
      cls_r       <= CLS_FG;
    end
    if (cmd.sqrt_step) begin
      sq_val_r <= {sq_val_r[31:0], 2'b00};
      if (sq_rem4 >= sq_trial) begin
        sq_rem_r <= 19'(sq_rem4 - sq_trial);
        ii_r     <= {ii_r[15:0], 1'b1};
      end else begin
        sq_rem_r <= 19'(sq_rem4);
        ii_r     <= {ii_r[15:0], 1'b0};
      end
    end
    if (cmd.cnt_load) n_r <= cnt_rdata;
    if (cmd.ld_word) begin
      w_r   <= wd_rdata;
      col_r <= '0;
    end
    if (cmd.m1) begin
      for (int c = 0; c < 3; c++) begin
        xv_r[c] <= 24'(x_r[c]) * 24'(w_r.color[c]);
        vv_r[c] <= 32'(w_r.color[c]) * 32'(w_r.color[c]);
      end
    end
    if (cmd.m2) begin
      d_r <= 26'(xv_r[0]) + 26'(xv_r[1]) + 26'(xv_r[2]);
      v_r <= 34'(vv_r[0]) + 34'(vv_r[1]) + 34'(vv_r[2]);
    end
    if (cmd.m3) begin
      pvl_r <= 50'(p2_r) * 50'(v_r[31:0]);
      pvh_r <= 20'(p2_r) * 20'(v_r[33:32]);
      dd_r  <= 52'(d_r) * 52'(d_r);
      evl_r <= 52'(eps2_r) * 52'(v_r[31:0]);
      evh_r <= 22'(eps2_r) * 22'(v_r[33:32]);
      a7m_r <= 28'(alpha7_r) * 28'(w_r.imax);
      b3m_r <= 28'(beta3_r) * 28'(w_r.imax);
      ai_r  <= 25'(ii_r) * 25'(alpha_r);
    end
    if (cmd.m4) begin
      pv_r   <= 52'(pvl_r) + {pvh_r, 32'b0};
      ev_r   <= 54'(evl_r) + {evh_r, 32'b0};
      band_r <= (32'({ii_r, 11'b0}) + 32'({ii_r, 9'b0}) >= 32'(a7m_r)) &&
                (32'({ii_r, 9'b0}) <= 32'(b3m_r)) &&
                (32'({ai_r, 1'b0}) <= 32'({w_r.imin, 9'b0}) + 32'({w_r.imin, 8'b0}));
    end
    if (cmd.m5) match_r <= active_r && color_ok && band_r;
    if (cmd.mul) prod_r <= 32'(w_r.color[col_r]) * 32'(w_r.freq);
    if (cmd.num) begin
      div_r <= 33'(prod_r) + 33'({x_r[col_r], 8'b0}) + 33'(dvs >> 1);
    end
    if (cmd.div_step) div_r <= {div_ts[16:0], div_r[14:0], div_ge};
    if (cmd.wr_col) begin
      w_r.color[col_r] <= div_r[15:0];
      col_r            <= col_r + 2'd1;
    end
    if (cmd.upd) begin
      if (ii_r < w_r.imin) w_r.imin <= ii_r;
      if (ii_r > w_r.imax) w_r.imax <= ii_r;
      if (w_r.freq != '1) w_r.freq <= w_r.freq + 16'd1;
      if (run_cur > w_r.idle_run) w_r.idle_run <= run_cur;
      w_r.last_t <= frame_cnt_r;
      if (w_r.cached) begin
        cache_r <= 1'b1;
        cls_r   <= CLS_CACHED;
      end else begin
        perm_r   <= 1'b1;
        active_r <= 1'b0;
        cls_r    <= absorb_ok ? CLS_BG : CLS_RECENT;
      end
    end
    if (cmd.prn) begin
      if (promote_ok) w_r.cached <= 1'b0;
      if (prune_upd) w_r.idle_run <= (prune_t[33:32] != 2'b00) ? '1 : prune_t[31:0];
    end
    if (cmd.finish) begin
      out_cls_r <= cls_r;
      out_fg_r  <= !training_r && (cls_r != CLS_BG);
      out_tr_r  <= training_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_class = out_cls_r;
  assign out_foreground  = out_fg_r;
  assign out_training    = out_tr_r;

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_prune_count: assert property (@(posedge clk) disable iff (!rst_n)
    mp_r <= k_r)
    else $error("more prune survivors than words visited");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && !out_range_r) |-> (mf_r <= CW'(WORDS_PER_PIXEL)))
    else $error("word count beyond store size");

endmodule

[rtl/codebook_background_pixel_update.sv]
// Top level of the codebook background pixel update block.
// A pixel is taken when start is high and busy is low; its class comes out
// on out_* for one cycle with out_valid, and the receiver cannot stall it.
// The block handles one pixel at a time: a pixel whose index lies outside the
// frame goes straight from the sqrt to the result; otherwise each stored word is
// read in turn from the codeword RAM, and each word that matches gets three
// 16-step divisions of the mean update on the shared divide unit. The intensity
// comes from the shared sqrt unit. After reset a clearing pass zeroes the
// per-pixel word counts; busy stays high meanwhile, while configuration writes
// are taken at any time.
module codebook_background_pixel_update #(
  parameter int PIXELS = 16384,
  parameter int WORDS_PER_PIXEL = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [13:0]                      in_pixel_index,
  input  logic                             in_frame_start,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_red,
  output logic                             out_valid,
  output logic [1:0]                       out_pixel_class,
  output logic                             out_foreground,
  output logic                             out_training,
  input  logic                             cfg_we,
  input  logic [cbpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbpu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cbpu_pkg::*;

  localparam int CAW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int AW  = (PIXELS * WORDS_PER_PIXEL > 1) ? $clog2(PIXELS * WORDS_PER_PIXEL) : 1;
  localparam int CW  = $clog2(WORDS_PER_PIXEL + 1);

  cmd_t    cmd;
  status_t st;

  logic           cnt_we;
  logic [CAW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0]  cnt_wdata, cnt_rdata;
  logic           wd_we;
  logic [AW-1:0]  wd_waddr, wd_raddr;
  word_t          wd_wdata, wd_rdata;

  cbpu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  cbpu_dp #(
    .PIXELS          (PIXELS),
    .WORDS_PER_PIXEL (WORDS_PER_PIXEL)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_pixel_index  (in_pixel_index),
    .in_frame_start  (in_frame_start),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cnt_we          (cnt_we),
    .cnt_waddr       (cnt_waddr),
    .cnt_wdata       (cnt_wdata),
    .cnt_raddr       (cnt_raddr),
    .cnt_rdata       (cnt_rdata),
    .wd_we           (wd_we),
    .wd_waddr        (wd_waddr),
    .wd_wdata        (wd_wdata),
    .wd_raddr        (wd_raddr),
    .wd_rdata        (wd_rdata),
    .out_valid       (out_valid),
    .out_pixel_class (out_pixel_class),
    .out_foreground  (out_foreground),
    .out_training    (out_training)
  );

  // per-pixel word count
  cbpu_ram #(
    .WIDTH (CW),
    .DEPTH (PIXELS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // codeword store, WORDS_PER_PIXEL entries per pixel
  cbpu_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (PIXELS * WORDS_PER_PIXEL)
  ) u_word_ram (
    .clk   (clk),
    .we    (wd_we),
    .waddr (wd_waddr),
    .wdata (wd_wdata),
    .raddr (wd_raddr),
    .rdata (wd_rdata)
  );

endmodule

[dv/cbpu_checker.sv]
// Checker for the codebook pixel update block: predicts each class and compares results.
module cbpu_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [13:0]                     in_pixel_index,
  input  logic                            in_frame_start,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_red,
  input  logic                            out_valid,
  input  logic [1:0]                      out_pixel_class,
  input  logic                            out_foreground,
  input  logic                            out_training,
  input  logic                            cfg_we,
  input  logic [cbpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbpu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);
  import cbpu_pkg::*;

  localparam int NPIX  = 16384;
  localparam int NWORD = 8;

  typedef struct {
    logic [2:0][15:0] col;
    int unsigned      imin;
    int unsigned      imax;
    int unsigned      freq;
    int unsigned      idle;
    int unsigned      first_t;
    int unsigned      last_t;
    bit               cached;
  } cw_t;

  typedef struct {
    logic [1:0] cls;
    logic       fg;
    logic       tr;
  } class_exp_t;

  int unsigned tf_q, alpha_q, beta_q, eps_q, cto_q, promo_q, pto_q, absorb_q;
  int unsigned frame_cnt;
  bit          training;
  int unsigned wcount [NPIX];
  cw_t         book [NPIX*NWORD];
  class_exp_t  class_q [$];
  int          n_pred, n_seen;

  assign pending = n_pred - n_seen;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned cand;
    res = 0;
    for (int b = 20; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  function automatic class_exp_t predict_class(int unsigned idx, bit fs,
                                               logic [7:0] b, logic [7:0] g, logic [7:0] r);
    longint unsigned x [3];
    longint unsigned p2, ii, fc, d, v, eps2, lhs, mx, mn, f, run, lim, first;
    longint t;
    int unsigned n, m, base, e;
    bit perm, cache, tr;
    logic [1:0] cls;
    class_exp_t res;
    x[0] = b; x[1] = g; x[2] = r;
    perm = 0; cache = 0; cls = CLS_FG;
    if (fs) begin
      if (frame_cnt != 0 && frame_cnt >= tf_q) training = 0;
      if (frame_cnt != 32'hFFFF_FFFF) frame_cnt++;
    end
    tr = training;
    fc = frame_cnt;
    if (idx >= NPIX) begin
      res.cls = CLS_FG; res.fg = !tr; res.tr = tr;
      return res;
    end
    p2 = x[0]*x[0] + x[1]*x[1] + x[2]*x[2];
    ii = int_sqrt(p2 << 16);
    base = idx * NWORD;
    n = wcount[idx];
    for (int k = 0; k < n; k++) begin
      e = base + k;
      d = 0; v = 0;
      for (int c = 0; c < 3; c++) begin
        d += x[c] * longint'(book[e].col[c]);
        v += longint'(book[e].col[c]) * longint'(book[e].col[c]);
      end
      eps2 = longint'(eps_q) * eps_q;
      lhs = p2 * v - d * d;
      mx = book[e].imax;
      mn = book[e].imin;
      if ((v == 0) ? (p2 <= eps2) : (lhs <= eps2 * v)) begin
        if (ii * 2560 >= 7 * longint'(alpha_q) * mx &&
            ii * 512 <= 3 * longint'(beta_q) * mx &&
            ii * 2 * alpha_q <= 768 * mn) begin
          f = book[e].freq;
          for (int c = 0; c < 3; c++)
            book[e].col[c] = 16'((longint'(book[e].col[c]) * f + 256 * x[c] + (f + 1) / 2)
                                 / (f + 1));
          if (ii < mn) book[e].imin = 32'(ii);
          if (ii > mx) book[e].imax = 32'(ii);
          if (f < 16'hFFFF) book[e].freq = 32'(f + 1);
          run = (fc >= book[e].last_t) ? fc - book[e].last_t : 0;
          if (run > book[e].idle) book[e].idle = 32'(run);
          book[e].last_t = 32'(fc);
          if (!book[e].cached) begin
            first = book[e].first_t;
            perm = 1;
            cls = (first + absorb_q <= fc || first <= tf_q) ? CLS_BG : CLS_RECENT;
            break;
          end
          cache = 1;
          cls = CLS_CACHED;
        end
      end
      if (!tr && book[e].cached && fc >= longint'(book[e].first_t) + promo_q)
        book[e].cached = 0;
    end
    // end of training: prune words idle for more than half the training length
    if (fc == tf_q) begin
      m = 0;
      for (int k = 0; k < n; k++) begin
        e = base + k;
        t = longint'(tf_q) - longint'(book[e].last_t) + longint'(book[e].first_t) - 1;
        if (t > 64'sh0_FFFF_FFFF) t = 64'sh0_FFFF_FFFF;
        if (t > longint'(book[e].idle)) book[e].idle = 32'(t);
        if (book[e].idle > tf_q / 2) continue;
        book[base + m] = book[e];
        m++;
      end
      n = m;
    end
    if (!perm && !cache) begin
      if (n < NWORD) begin
        e = base + n;
        for (int c = 0; c < 3; c++) book[e].col[c] = 16'(x[c] << 8);
        book[e].imin = 32'(ii);
        book[e].imax = 32'(ii);
        book[e].freq = 1;
        book[e].idle = fc ? 32'(fc - 1) : 0;
        book[e].first_t = 32'(fc);
        book[e].last_t = 32'(fc);
        book[e].cached = !tr;
        n++;
      end
      cls = CLS_FG;
    end
    if (!tr) begin
      m = 0;
      for (int k = 0; k < n; k++) begin
        e = base + k;
        lim = book[e].cached ? cto_q : pto_q;
        if (fc >= longint'(book[e].last_t) + lim) continue;
        book[base + m] = book[e];
        m++;
      end
      n = m;
    end
    wcount[idx] = n;
    res.cls = cls; res.fg = !tr && cls != CLS_BG; res.tr = tr;
    return res;
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch %0s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    class_exp_t want;
    if (!rst_n) begin
      tf_q = RST_TRAINING_FRAMES; alpha_q = RST_ALPHA_Q8; beta_q = RST_BETA_Q8;
      eps_q = RST_COLOR_EPSILON; cto_q = RST_CACHE_TIMEOUT; promo_q = RST_PROMOTE_AGE;
      pto_q = RST_PERMANENT_TIMEOUT; absorb_q = RST_ABSORB_AGE;
      frame_cnt = 0; training = 1;
      foreach (wcount[i]) wcount[i] = 0;
      class_q.delete();
      n_pred <= 0; n_seen <= 0;
      errors = 0;
    end else begin
      if (out_valid) begin
        if (class_q.size() == 0) begin
          // result transaction with nothing predicted
          report("result count", n_seen + 1, n_pred);
        end else begin
          want = class_q.pop_front();
          if (out_pixel_class !== want.cls) report("pixel_class", out_pixel_class, want.cls);
          if (out_foreground !== want.fg) report("foreground", out_foreground, want.fg);
          if (out_training !== want.tr) report("training", out_training, want.tr);
        end
        n_seen <= n_seen + 1;
      end
      if (start && !busy) begin
        class_q.insert(class_q.size(), predict_class(in_pixel_index, in_frame_start,
                                                     in_blue, in_green, in_red));
        n_pred <= n_pred + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TRAINING_FRAMES:   tf_q = cfg_wdata;
          REG_ALPHA_Q8:          alpha_q = cfg_wdata[7:0];
          REG_BETA_Q8:           beta_q = cfg_wdata[8:0];
          REG_COLOR_EPSILON:     eps_q = cfg_wdata[9:0];
          REG_CACHE_TIMEOUT:     cto_q = cfg_wdata;
          REG_PROMOTE_AGE:       promo_q = cfg_wdata;
          REG_PERMANENT_TIMEOUT: pto_q = cfg_wdata;
          REG_ABSORB_AGE:        absorb_q = cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

[dv/codebook_background_pixel_update_tb.sv]
// Testbench top: drives pixels and configuration, watches progress, gives the verdict.
module codebook_background_pixel_update_tb;
  import cbpu_pkg::*;

  localparam int WATCH_LIMIT = 60000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [13:0]           in_pixel_index = '0;
  logic                  in_frame_start = 1'b0;
  logic [7:0]            in_blue = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_red = '0;
  logic                  out_valid;
  logic [1:0]            out_pixel_class;
  logic                  out_foreground;
  logic                  out_training;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    errors;
  int                    pending;
  int                    stall_cycles = 0;
  int                    frames_sent = 0;
  logic [23:0]           base_color [8];

  codebook_background_pixel_update DUT (.*);

  cbpu_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one pixel transaction; returns just after the accepting edge
  task automatic send_pixel(int idx, bit fs, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    start <= 1'b1;
    in_pixel_index <= 14'(idx);
    in_frame_start <= fs;
    in_blue <= b; in_green <= g; in_red <= r;
    if (fs) frames_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
  endtask

  task automatic load_config(int unsigned tf, int unsigned al, int unsigned be,
                             int unsigned ep, int unsigned cto, int unsigned pro,
                             int unsigned pto, int unsigned ab);
    cfg_write(REG_TRAINING_FRAMES, tf);
    cfg_write(REG_ALPHA_Q8, al);
    cfg_write(REG_BETA_Q8, be);
    cfg_write(REG_COLOR_EPSILON, ep);
    cfg_write(REG_CACHE_TIMEOUT, cto);
    cfg_write(REG_PROMOTE_AGE, pro);
    cfg_write(REG_PERMANENT_TIMEOUT, pto);
    cfg_write(REG_ABSORB_AGE, ab);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // frames of a few pixels drawn mostly from a small pool of positions
  task automatic random_frames(int count);
    int sent, len, slot, idx;
    logic [23:0] c;
    bit noisy;
    sent = 0;
    foreach (base_color[i]) base_color[i] = 24'($urandom);
    while (sent < count) begin
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) base_color[$urandom_range(0, 7)] = 24'($urandom);
      for (int p = 0; p < len; p++) begin
        slot = $urandom_range(0, 7);
        idx = (slot == 7) ? 16383 : slot;
        noisy = $urandom_range(0, 9) == 0;
        if (noisy) idx = $urandom_range(0, 16383);
        c = noisy ? 24'($urandom) : base_color[slot];
        send_pixel(idx, p == 0 || $urandom_range(0, 49) == 0,
                   jitter(c[7:0]), jitter(c[15:8]), jitter(c[23:16]));
        idle_cycles(pick_gap());
        sent++;
      end
      // a stretch without gaps now and then
      if ($urandom_range(0, 9) == 0) begin
        for (int p = 0; p < 12; p++) begin
          slot = $urandom_range(0, 7);
          c = base_color[slot];
          send_pixel(slot == 7 ? 16383 : slot, p == 0, c[7:0], c[15:8], c[23:16]);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    load_config(4, 205, 282, 20, 3, 5, 10, 2);

    // directed: pixel before any frame start, black, white, full store
    send_pixel(1, 0, 8'd10, 8'd20, 8'd30);
    send_pixel(0, 1, 8'd0, 8'd0, 8'd0);
    send_pixel(0, 0, 8'd0, 8'd0, 8'd0);
    send_pixel(16383, 0, 8'd255, 8'd255, 8'd255);
    send_pixel(16383, 0, 8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 9; i++)
      send_pixel(2, 0, 8'(i * 28), 8'(255 - i * 28), 8'(i * 13));
    send_pixel(2, 1, 8'd0, 8'd255, 8'd0);
    send_pixel(3, 1, 8'd128, 8'd64, 8'd32);
    send_pixel(3, 1, 8'd129, 8'd64, 8'd31);
    send_pixel(3, 1, 8'd128, 8'd65, 8'd32);
    send_pixel(3, 1, 8'd255, 8'd0, 8'd255);
    random_frames(180);
    drain();

    load_config(frames_sent + 3, 255, 511, 1023, 0, 0, 0, 0);
    random_frames(190);
    drain();

    load_config(65535, 1, 256, 0, 65535, 65535, 65535, 65535);
    random_frames(190);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      load_config((ph == 0) ? frames_sent + 4 : $urandom_range(1, 65535),
                  (ph == 1) ? 0 : $urandom_range(1, 255),
                  (ph == 2) ? $urandom_range(0, 255) : $urandom_range(256, 511),
                  $urandom_range(0, 60), $urandom_range(0, 12), $urandom_range(0, 12),
                  $urandom_range(0, 40), $urandom_range(0, 8));
      random_frames(190);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[codebook_background_pixel_update.f]
rtl/cbpu_pkg.sv
rtl/cbpu_ram.sv
rtl/cbpu_ctrl.sv
rtl/cbpu_dp.sv
rtl/codebook_background_pixel_update.sv
dv/cbpu_checker.sv
dv/codebook_background_pixel_update_tb.sv
